[design/pal_pkg.sv]
// Shared constants, codes and controller/datapath handshake types for the positional list.
package pal_pkg;

    // Field widths of one entry
    localparam int unsigned KEY_W = 32;
    localparam int unsigned PAY_W = 64;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_LOCATE = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OVERFLOW  = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW = 3'd2;
    localparam logic [2:0] ST_RANGE     = 3'd3;
    localparam logic [2:0] ST_NOTFOUND  = 3'd4;

    // Capacity register value after reset
    localparam logic [6:0] CAP_RESET = 7'd64;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // latch a new transaction and set up the engine
        logic shift;   // one step of the insert/delete move engine
        logic scan;    // one step of the locate scan
        logic found;   // record a locate hit
        logic put;     // write the new entry and bump the length
        logic drop;    // shrink the length after a delete
        logic report;  // load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic go_shift;   // accepted command needs the move engine
        logic go_scan;    // accepted command needs the scan
        logic is_insert;  // latched command is an insert
        logic busy;       // engine still has reads or a write pending
        logic hit;        // scan data in hand matches the key
        logic out_free;   // result register can take a new result
    } t_dp_stat;

endpackage

[design/pal_ifs.sv]
// Valid/ready channel interfaces for commands, results and configuration.
interface pal_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic [7:0]         position;
    logic signed [31:0] entry_key;
    logic [63:0]        entry_payload;

    modport source (output valid, command, position, entry_key, entry_payload, input ready);
    modport sink   (input valid, command, position, entry_key, entry_payload, output ready);
endinterface

interface pal_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [6:0] found_position;
    logic [6:0] length;

    modport source (output valid, status, found_position, length, input ready);
    modport sink   (input valid, status, found_position, length, output ready);
endinterface

interface pal_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] capacity;

    modport source (output valid, capacity, input ready);
    modport sink   (input valid, capacity, output ready);
endinterface

[design/positional_array_list.sv]
// Positional list top level: one command at a time, entries held in a single-port-pair RAM.
// Rejected commands (overflow, underflow, bad position) and unused codes skip the engine and go to the result;
// one entry moved or compared per cycle; the next command can be taken in the same cycle the result is valid.
// Reset empties the list and sets capacity to 64; entry storage itself is not cleared.
module positional_array_list #(
    parameter int DEPTH = 64
) (
    input logic      i_clk,
    input logic      i_rst_n,
    pal_cmd_if.sink   i_cmd,
    pal_rsp_if.source o_rsp,
    pal_cfg_if.sink   i_cfg
);
    import pal_pkg::*;

    t_dp_cmd  w_dp_cmd;
    t_dp_stat w_dp_stat;
    logic     w_ready;

    assign i_cmd.ready = w_ready;

    pal_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.valid),
        .o_ready (w_ready),
        .i_stat  (w_dp_stat),
        .o_cmd   (w_dp_cmd)
    );

    pal_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_dp_cmd),
        .o_stat           (w_dp_stat),
        .i_command        (i_cmd.command),
        .i_position       (i_cmd.position),
        .i_entry_key      (i_cmd.entry_key),
        .i_entry_payload  (i_cmd.entry_payload),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_capacity   (i_cfg.capacity),
        .o_cfg_ready      (i_cfg.ready),
        .o_valid          (o_rsp.valid),
        .i_ready          (o_rsp.ready),
        .o_status         (o_rsp.status),
        .o_found_position (o_rsp.found_position),
        .o_length         (o_rsp.length)
    );

    // Block takes no new transaction until the previous one has returned to idle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.valid && i_cmd.ready) |=> !i_cmd.ready)
        else $error("command accepted while previous one still in progress");

    // Controller issues at most one datapath operation per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_dp_cmd.load, w_dp_cmd.shift, w_dp_cmd.scan, w_dp_cmd.found,
                  w_dp_cmd.put, w_dp_cmd.drop, w_dp_cmd.report}))
        else $error("conflicting datapath commands");

    // A reported position only comes with a successful locate
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.found_position != '0)) |-> (o_rsp.status == ST_OK))
        else $error("found position reported with a failing status");

endmodule

[design/pal_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pal_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/pal_ctrl.sv]
// Controller state machine that sequences insert, delete and locate transactions.
module pal_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pal_pkg::t_dp_stat i_stat,
    output pal_pkg::t_dp_cmd  o_cmd
);
    import pal_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SHIFT  = 5'b00010,
        S_PUT    = 5'b00100,
        S_SCAN   = 5'b01000,
        S_REPORT = 5'b10000
    } t_ctrl_state;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    assign o_ready = (r_state == S_IDLE);

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.go_shift) begin
                        n_state = S_SHIFT;
                    end else if (i_stat.go_scan) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_REPORT;
                    end
                end
            end
            S_SHIFT: begin
                if (i_stat.busy) begin
                    o_cmd.shift = 1'b1;
                end else if (i_stat.is_insert) begin
                    n_state = S_PUT;
                end else begin
                    o_cmd.drop = 1'b1;
                    n_state    = S_REPORT;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_state   = S_REPORT;
            end
            S_SCAN: begin
                if (i_stat.hit) begin
                    o_cmd.found = 1'b1;
                    n_state     = S_REPORT;
                end else if (i_stat.busy) begin
                    o_cmd.scan = 1'b1;
                end else begin
                    n_state = S_REPORT;
                end
            end
            S_REPORT: begin
                if (i_stat.out_free) begin
                    o_cmd.report = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[design/pal_dp.sv]
// Datapath: entry RAM, move/scan engine, length and capacity registers, result register.
module pal_dp #(
    parameter int DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pal_pkg::t_dp_cmd            i_cmd,
    output pal_pkg::t_dp_stat           o_stat,
    input  logic [1:0]                  i_command,
    input  logic [7:0]                  i_position,
    input  logic signed [31:0]          i_entry_key,
    input  logic [63:0]                 i_entry_payload,
    input  logic                        i_cfg_valid,
    input  logic [6:0]                  i_cfg_capacity,
    output logic                        o_cfg_ready,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [2:0]                  o_status,
    output logic [6:0]                  o_found_position,
    output logic [6:0]                  o_length
);
    import pal_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (CW > 8) ? CW : 8;
    localparam int EW = KEY_W + PAY_W;

    // Control registers
    logic [CW-1:0] r_count, n_count;
    logic [6:0]    r_cap, n_cap;
    logic          r_ovalid, n_ovalid;
    logic [AW-1:0] r_src, n_src;
    logic [CW-1:0] r_left, n_left;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_wa, n_wa;

    // Transaction and result registers
    logic [1:0]       r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_pay;
    logic [AW-1:0]    r_pa;
    logic [2:0]       r_status;
    logic [6:0]       r_found;
    logic [2:0]       r_o_status;
    logic [6:0]       r_o_found;
    logic [6:0]       r_o_length;

    // RAM port signals
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic [EW-1:0] w_rdata;

    // Load decode
    logic [XW-1:0] w_count_x, w_pos_x, w_cap_x, w_eff_cap;
    logic          w_full, w_del_bad, w_is_ins;
    logic [CW-1:0] w_p0;
    logic [2:0]    w_ld_status;
    logic          w_go_shift, w_go_scan;
    logic [AW-1:0] w_ld_src;
    logic [CW-1:0] w_ld_left;
    logic          w_hit;

    pal_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_src),
        .o_rdata (w_rdata)
    );

    // Effective capacity, insert clamp and delete range check
    always_comb begin
        w_count_x = XW'(r_count);
        w_pos_x   = XW'(i_position);
        w_cap_x   = XW'(r_cap);
        w_eff_cap = (w_cap_x > XW'(DEPTH)) ? XW'(DEPTH) : w_cap_x;
        w_full    = (w_count_x >= w_eff_cap);
        w_del_bad = (w_pos_x == '0) || (w_pos_x > w_count_x);
        if (w_pos_x == '0) begin
            w_p0 = '0;
        end else if (w_pos_x > w_count_x) begin
            w_p0 = r_count;
        end else begin
            w_p0 = CW'(w_pos_x - XW'(1));
        end
    end

    // Decode a new transaction into a preset status and engine setup
    always_comb begin
        w_ld_status = ST_OK;
        w_go_shift  = 1'b0;
        w_go_scan   = 1'b0;
        w_ld_src    = AW'(r_count - CW'(1));
        w_ld_left   = '0;
        case (i_command)
            CMD_INSERT: begin
                if (w_full) begin
                    w_ld_status = ST_OVERFLOW;
                end else begin
                    w_go_shift = 1'b1;
                    w_ld_left  = r_count - w_p0;
                end
            end
            CMD_DELETE: begin
                if (r_count == '0) begin
                    w_ld_status = ST_UNDERFLOW;
                end else if (w_del_bad) begin
                    w_ld_status = ST_RANGE;
                end else begin
                    w_go_shift = 1'b1;
                    w_ld_src   = AW'(i_position);
                    w_ld_left  = r_count - CW'(i_position);
                end
            end
            CMD_LOCATE: begin
                w_ld_status = ST_NOTFOUND;
                w_go_scan   = 1'b1;
                w_ld_src    = '0;
                w_ld_left   = r_count;
            end
            default: begin
                w_ld_status = ST_OK;
            end
        endcase
    end

    assign w_is_ins = (r_cmd == CMD_INSERT);
    assign w_hit    = r_pend && (w_rdata[EW-1 -: KEY_W] == r_key);

    // Status to the controller
    always_comb begin
        o_stat           = '0;
        o_stat.go_shift  = w_go_shift;
        o_stat.go_scan   = w_go_scan;
        o_stat.is_insert = w_is_ins;
        o_stat.busy      = (r_left != '0) || r_pend;
        o_stat.hit       = w_hit;
        o_stat.out_free  = !r_ovalid || i_ready;
    end

    // Engine, length, capacity and result-valid next values; RAM write select
    always_comb begin
        n_count  = r_count;
        n_cap    = r_cap;
        n_ovalid = r_ovalid;
        n_src    = r_src;
        n_left   = r_left;
        n_pend   = r_pend;
        n_wa     = r_wa;
        w_we     = 1'b0;
        w_waddr  = r_wa;
        w_wdata  = w_rdata;

        if (i_cfg_valid) begin
            n_cap = i_cfg_capacity;
        end
        if (r_ovalid && i_ready) begin
            n_ovalid = 1'b0;
        end
        if (i_cmd.load) begin
            n_src  = w_ld_src;
            n_left = w_ld_left;
            n_pend = 1'b0;
        end
        // One entry per step: a move writes back what was read, and each step reads the next
        if (i_cmd.shift || i_cmd.scan) begin
            if (r_pend && i_cmd.shift) begin
                w_we = 1'b1;
            end
            if (r_left != '0) begin
                n_pend = 1'b1;
                n_left = r_left - CW'(1);
                if (i_cmd.scan) begin
                    n_wa  = r_src;
                    n_src = r_src + AW'(1);
                end else if (w_is_ins) begin
                    n_wa  = r_src + AW'(1);
                    n_src = r_src - AW'(1);
                end else begin
                    n_wa  = r_src - AW'(1);
                    n_src = r_src + AW'(1);
                end
            end else begin
                n_pend = 1'b0;
            end
        end
        if (i_cmd.put) begin
            w_we    = 1'b1;
            w_waddr = r_pa;
            w_wdata = {r_key, r_pay};
            n_count = r_count + CW'(1);
        end
        if (i_cmd.drop) begin
            n_count = r_count - CW'(1);
        end
        if (i_cmd.report) begin
            n_ovalid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cap    <= CAP_RESET;
            r_ovalid <= 1'b0;
            r_src    <= '0;
            r_left   <= '0;
            r_pend   <= 1'b0;
            r_wa     <= '0;
        end else begin
            r_count  <= n_count;
            r_cap    <= n_cap;
            r_ovalid <= n_ovalid;
            r_src    <= n_src;
            r_left   <= n_left;
            r_pend   <= n_pend;
            r_wa     <= n_wa;
        end
    end

    // Transaction fields and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd    <= i_command;
            r_key    <= i_entry_key;
            r_pay    <= i_entry_payload;
            r_pa     <= AW'(w_p0);
            r_status <= w_ld_status;
            r_found  <= '0;
        end
        if (i_cmd.found) begin
            r_status <= ST_OK;
            r_found  <= 7'((AW+1)'({1'b0, r_wa}) + (AW+1)'(1));
        end
        if (i_cmd.report) begin
            r_o_status <= r_status;
            r_o_found  <= r_found;
            r_o_length <= 7'(r_count);
        end
    end

    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_ovalid;
    assign o_status         = r_o_status;
    assign o_found_position = r_o_found;
    assign o_length         = r_o_length;

endmodule
